### sv/mpt_pkg.sv
// Shared types, constants and meter rules of the metric position tracker.
package mpt_pkg;

    localparam int TIME_BITS_DEF    = 24;
    localparam int MAX_SEGMENTS_DEF = 4096;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int CAP_W      = 10;
    localparam int SIM_W      = 9;
    localparam int MEAS_W     = 25;
    localparam int POS_W      = 12;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BEATS    = 2'd0,
        CFG_UNIT     = 2'd1,
        CFG_PICKUP   = 2'd2,
        CFG_SEGMENTS = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        BEAT_STRONG = 2'd0,
        BEAT_MEDIUM = 2'd1,
        BEAT_WEAK   = 2'd2
    } beat_class_t;

    typedef enum logic [1:0] {
        ZONE_BEGIN  = 2'd0,
        ZONE_MIDDLE = 2'd1,
        ZONE_END    = 2'd2
    } zone_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_HOLD
    } mpt_state_t;

    // Sixteenths in one beat; zero where the beat unit has no meaning.
    function automatic logic [4:0] sixteenths_per_beat(input logic [4:0] unit);
        logic [4:0] r;
        begin
            unique case (unit)
                5'd1:                                r = 5'd16;
                5'd2:                                r = 5'd8;
                5'd3:                                r = 5'd5;
                5'd4:                                r = 5'd4;
                5'd5:                                r = 5'd3;
                5'd6, 5'd7, 5'd8:                    r = 5'd2;
                5'd9, 5'd10, 5'd11, 5'd12,
                5'd13, 5'd14, 5'd15, 5'd16:          r = 5'd1;
                default:                             r = 5'd0;
            endcase
            return r;
        end
    endfunction

    function automatic beat_class_t classify_beat(input logic [CAP_W-1:0] s,
                                                  input logic [5:0] beats,
                                                  input logic [4:0] unit);
        logic accent_strong;
        logic accent_medium;
        begin
            accent_strong = (s == 10'd0)
                  || (unit == 5'd4 && beats == 6'd4 && s == 10'd8)
                  || (unit == 5'd8 && beats == 6'd12 && s == 10'd12);
            accent_medium = (unit == 5'd4 && beats == 6'd3 && s == 10'd4)
                  || (unit == 5'd8 && beats == 6'd6 && s == 10'd6)
                  || (unit == 5'd8 && beats == 6'd9 && (s == 10'd6 || s == 10'd12))
                  || (unit == 5'd8 && beats == 6'd12 && (s == 10'd6 || s == 10'd18));
            if (accent_strong)
                return BEAT_STRONG;
            else if (accent_medium)
                return BEAT_MEDIUM;
            else
                return BEAT_WEAK;
        end
    endfunction

endpackage

### sv/mpt_divider.sv
// Restoring bit-serial divider: one quotient bit per clock cycle.
module mpt_divider #(
    parameter int TIME_BITS = mpt_pkg::TIME_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [TIME_BITS-1:0]     dividend,
    input  logic [mpt_pkg::CAP_W-1:0] divisor,
    output logic                     done,
    output logic [TIME_BITS-1:0]     quotient,
    output logic [mpt_pkg::CAP_W-1:0] remainder
);

    localparam int CW = $clog2(TIME_BITS + 1);

    logic                      busy_reg;
    logic                      busy_next;
    logic                      done_reg;
    logic                      done_next;
    logic [CW-1:0]             cnt_reg;
    logic [CW-1:0]             cnt_next;
    logic [TIME_BITS-1:0]      q_reg;
    logic [mpt_pkg::CAP_W-1:0] rem_reg;
    logic [mpt_pkg::CAP_W-1:0] div_reg;
    logic [mpt_pkg::CAP_W:0]   trial;
    logic [mpt_pkg::CAP_W:0]   diff;
    logic                      ge;

    assign trial = {rem_reg, q_reg[TIME_BITS-1]};
    assign ge    = trial >= {1'b0, div_reg};
    assign diff  = trial - {1'b0, div_reg};

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(TIME_BITS);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            q_reg   <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            q_reg   <= {q_reg[TIME_BITS-2:0], ge};
            rem_reg <= ge ? diff[mpt_pkg::CAP_W-1:0] : trial[mpt_pkg::CAP_W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

### sv/metric_position_tracker.sv
// Top level of the metric position tracker: counters, sequencing and result register.
// Each transaction carries one note segment and produces one result. An item is accepted,
// then the bit-serial divider splits the time after the pickup by the measure capacity and
// flags completion, and then the result register is loaded once the previous result is no
// longer stalled. Segments in the pickup or with a zero capacity skip the divider and go
// straight to the load. The result register lets the next transaction in while an earlier
// result is still stalled. Configuration writes take effect at once and are meant for idle
// periods only.
module metric_position_tracker #(
    parameter int TIME_BITS    = mpt_pkg::TIME_BITS_DEF,
    parameter int MAX_SEGMENTS = mpt_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mpt_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [mpt_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [9:0]                    duration_sixteenths,
    input  logic [6:0]                    fixed_note,
    input  logic [11:0]                   source_note_index,
    input  logic [9:0]                    offset_in_note,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [mpt_pkg::MEAS_W-1:0]    measure_number,
    output logic [mpt_pkg::SIM_W-1:0]     start_in_measure,
    output logic [9:0]                    duration_out,
    output logic [6:0]                    note_out,
    output logic [11:0]                   source_index_out,
    output logic [9:0]                    offset_out,
    output logic [1:0]                    beat_class,
    output logic [mpt_pkg::POS_W-1:0]     position_number,
    output logic [1:0]                    phrase_zone
);

    localparam int CNT_BITS = $clog2(MAX_SEGMENTS);
    localparam int ZW       = (CNT_BITS + 2 > 14) ? CNT_BITS + 2 : 14;
    localparam int QW       = TIME_BITS + 1;

    mpt_pkg::mpt_state_t state_reg;
    mpt_pkg::mpt_state_t state_next;

    logic [5:0]                 beats_reg;
    logic [4:0]                 unit_reg;
    logic [7:0]                 pickup_reg;
    logic [12:0]                segs_reg;
    logic [TIME_BITS-1:0]       rs_reg;
    logic [TIME_BITS-1:0]       rs_next;
    logic [CNT_BITS-1:0]        cnt_reg;
    logic [CNT_BITS-1:0]        cnt_next;
    logic                       out_valid_reg;
    logic                       out_valid_next;

    logic                       accept;
    logic                       load_out;
    logic                       in_pickup;
    logic                       cap_zero;
    logic [10:0]                cap_wide;
    logic [mpt_pkg::CAP_W-1:0]  cap;
    logic [TIME_BITS-1:0]       rel;
    logic [TIME_BITS:0]         rs_sum;
    logic [CNT_BITS:0]          next_cnt;
    logic [ZW-1:0]              pos3;
    logic [ZW-1:0]              seg_ext;
    logic                       wrap;
    mpt_pkg::zone_t             zone_now;

    logic                       div_start;
    logic                       div_done;
    logic [TIME_BITS-1:0]       div_q;
    logic [mpt_pkg::CAP_W-1:0]  div_r;

    logic                       pickup_mode_reg;
    logic                       zero_mode_reg;
    logic [7:0]                 pickup_sim_reg;
    logic [9:0]                 dur_reg;
    logic [6:0]                 note_reg;
    logic [11:0]                src_reg;
    logic [9:0]                 off_reg;
    logic [CNT_BITS-1:0]        pos_reg;
    mpt_pkg::zone_t             zone_reg;

    logic [QW-1:0]              q_plus;
    logic [QW+mpt_pkg::MEAS_W-1:0] q_ext;
    logic [CNT_BITS+mpt_pkg::POS_W-1:0] pos_ext;
    logic [mpt_pkg::MEAS_W-1:0] meas_sel;
    logic [mpt_pkg::CAP_W-1:0]  sim_sel;

    logic [mpt_pkg::MEAS_W-1:0] meas_out_reg;
    logic [mpt_pkg::SIM_W-1:0]  sim_out_reg;
    logic [9:0]                 dur_out_reg;
    logic [6:0]                 note_out_reg;
    logic [11:0]                src_out_reg;
    logic [9:0]                 off_out_reg;
    mpt_pkg::beat_class_t       cls_out_reg;
    logic [mpt_pkg::POS_W-1:0]  pos_out_reg;
    mpt_pkg::zone_t             zone_out_reg;

    assign in_stall = (state_reg != mpt_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    assign cap_wide  = 11'(beats_reg) * 11'(mpt_pkg::sixteenths_per_beat(unit_reg));
    assign cap       = cap_wide[mpt_pkg::CAP_W-1:0];
    assign cap_zero  = (cap == '0);
    assign in_pickup = (pickup_reg != 8'd0) && (rs_reg < TIME_BITS'(pickup_reg));
    assign rel       = rs_reg - TIME_BITS'(pickup_reg);
    assign div_start = accept && !in_pickup && !cap_zero;

    assign rs_sum   = {1'b0, rs_reg} + QW'(duration_sixteenths);
    assign next_cnt = {1'b0, cnt_reg} + 1'b1;
    assign seg_ext  = ZW'(segs_reg);
    assign pos3     = (ZW'(cnt_reg) << 1) + ZW'(cnt_reg);
    assign wrap     = (ZW'(next_cnt) >= seg_ext) || (ZW'(next_cnt) >= ZW'(MAX_SEGMENTS));

    always_comb
    begin
        priority if (pos3 < seg_ext)
            zone_now = mpt_pkg::ZONE_BEGIN;
        else if (pos3 >= (seg_ext << 1))
            zone_now = mpt_pkg::ZONE_END;
        else
            zone_now = mpt_pkg::ZONE_MIDDLE;
    end

    always_comb
    begin
        rs_next  = rs_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (wrap)
            begin
                rs_next  = '0;
                cnt_next = '0;
            end
            else
            begin
                cnt_next = next_cnt[CNT_BITS-1:0];
                rs_next  = rs_sum[TIME_BITS] ? '1 : rs_sum[TIME_BITS-1:0];
            end
        end
    end

    mpt_divider #(
        .TIME_BITS (TIME_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (rel),
        .divisor   (cap),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r)
    );

    always_comb
    begin
        state_next     = state_reg;
        load_out       = 1'b0;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            mpt_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = div_start ? mpt_pkg::ST_DIV : mpt_pkg::ST_HOLD;
            end
            mpt_pkg::ST_DIV:
            begin
                if (div_done)
                    state_next = mpt_pkg::ST_HOLD;
            end
            mpt_pkg::ST_HOLD:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = mpt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mpt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            rs_reg        <= '0;
            cnt_reg       <= '0;
            beats_reg     <= 6'd4;
            unit_reg      <= 5'd4;
            pickup_reg    <= 8'd0;
            segs_reg      <= 13'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rs_reg        <= rs_next;
            cnt_reg       <= cnt_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    mpt_pkg::CFG_BEATS:    beats_reg  <= cfg_data[5:0];
                    mpt_pkg::CFG_UNIT:     unit_reg   <= cfg_data[4:0];
                    mpt_pkg::CFG_PICKUP:   pickup_reg <= cfg_data[7:0];
                    mpt_pkg::CFG_SEGMENTS: segs_reg   <= cfg_data[12:0];
                    default:               segs_reg   <= segs_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pickup_mode_reg <= in_pickup;
            zero_mode_reg   <= cap_zero;
            pickup_sim_reg  <= rs_reg[7:0];
            dur_reg         <= duration_sixteenths;
            note_reg        <= fixed_note;
            src_reg         <= source_note_index;
            off_reg         <= offset_in_note;
            pos_reg         <= cnt_reg;
            zone_reg        <= zone_now;
        end
    end

    assign q_plus  = {1'b0, div_q} + 1'b1;
    assign q_ext   = {{mpt_pkg::MEAS_W{1'b0}}, q_plus};
    assign pos_ext = {{mpt_pkg::POS_W{1'b0}}, pos_reg};

    always_comb
    begin
        priority if (pickup_mode_reg)
        begin
            meas_sel = '0;
            sim_sel  = mpt_pkg::CAP_W'(pickup_sim_reg);
        end
        else if (zero_mode_reg)
        begin
            meas_sel = mpt_pkg::MEAS_W'(1);
            sim_sel  = '0;
        end
        else
        begin
            meas_sel = q_ext[mpt_pkg::MEAS_W-1:0];
            sim_sel  = div_r;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            meas_out_reg <= meas_sel;
            sim_out_reg  <= sim_sel[mpt_pkg::SIM_W-1:0];
            dur_out_reg  <= dur_reg;
            note_out_reg <= note_reg;
            src_out_reg  <= src_reg;
            off_out_reg  <= off_reg;
            cls_out_reg  <= mpt_pkg::classify_beat(sim_sel, beats_reg, unit_reg);
            pos_out_reg  <= pos_ext[mpt_pkg::POS_W-1:0];
            zone_out_reg <= zone_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign measure_number   = meas_out_reg;
    assign start_in_measure = sim_out_reg;
    assign duration_out     = dur_out_reg;
    assign note_out         = note_out_reg;
    assign source_index_out = src_out_reg;
    assign offset_out       = off_out_reg;
    assign beat_class       = cls_out_reg;
    assign position_number  = pos_out_reg;
    assign phrase_zone      = zone_out_reg;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == mpt_pkg::ST_DIV)
        else $error("divider finished outside the divide state");

    // An accepted transaction always leaves the idle state.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != mpt_pkg::ST_IDLE)
        else $error("accepted transaction did not start work");

    // A new result appears only after the hold state has loaded it.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == mpt_pkg::ST_HOLD)
        else $error("result became valid without a load");

    // The divider is started only for segments outside the pickup with a usable capacity.
    assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (!in_pickup && cap != '0 && state_reg == mpt_pkg::ST_IDLE))
        else $error("divider started for a bypassed segment");

endmodule

### verif/metric_position_tracker_test.sv
// Self-checking testbench for the metric position tracker: directed meters and random phrases.
module metric_position_tracker_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = mpt_pkg::TIME_BITS_DEF + 2;
    localparam int CYCLE_LIMIT = 2000000;
    localparam longint unsigned TIME_MAX = (64'd1 << mpt_pkg::TIME_BITS_DEF) - 64'd1;

    typedef struct {
        logic [9:0]  duration;
        logic [6:0]  note;
        logic [11:0] source;
        logic [9:0]  offset;
    } segment_t;

    typedef struct {
        logic [mpt_pkg::MEAS_W-1:0] measure;
        logic [mpt_pkg::SIM_W-1:0]  start;
        logic [9:0]                 duration;
        logic [6:0]                 note;
        logic [11:0]                source;
        logic [9:0]                 offset;
        mpt_pkg::beat_class_t       beat;
        logic [mpt_pkg::POS_W-1:0]  position;
        mpt_pkg::zone_t             zone;
    } placement_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           cfg_we = 1'b0;
    logic [mpt_pkg::CFG_IDX_W-1:0]  cfg_index = mpt_pkg::CFG_BEATS;
    logic [mpt_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    logic [9:0]                     duration_sixteenths = '0;
    logic [6:0]                     fixed_note = '0;
    logic [11:0]                    source_note_index = '0;
    logic [9:0]                     offset_in_note = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [mpt_pkg::MEAS_W-1:0]     measure_number;
    logic [mpt_pkg::SIM_W-1:0]      start_in_measure;
    logic [9:0]                     duration_out;
    logic [6:0]                     note_out;
    logic [11:0]                    source_index_out;
    logic [9:0]                     offset_out;
    logic [1:0]                     beat_class;
    logic [mpt_pkg::POS_W-1:0]      position_number;
    logic [1:0]                     phrase_zone;

    longint unsigned meter_beats = 4;
    longint unsigned meter_unit = 4;
    longint unsigned meter_pickup = 0;
    longint unsigned meter_segments = 1;
    longint unsigned phrase_time = 0;
    int unsigned     phrase_ordinal = 0;

    placement_t pending_placements[$];

    int  mismatch_count = 0;
    int  placements_checked = 0;
    int  settings_used = 0;
    int  pickup_placements = 0;
    int  class_seen[3] = '{0, 0, 0};
    int  cycle_count = 0;
    int  hold_left = 0;
    bit  idle_mode = 1'b0;

    metric_position_tracker dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg_we              (cfg_we),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .in_valid            (in_valid),
        .in_stall            (in_stall),
        .duration_sixteenths (duration_sixteenths),
        .fixed_note          (fixed_note),
        .source_note_index   (source_note_index),
        .offset_in_note      (offset_in_note),
        .out_valid           (out_valid),
        .out_stall           (out_stall),
        .measure_number      (measure_number),
        .start_in_measure    (start_in_measure),
        .duration_out        (duration_out),
        .note_out            (note_out),
        .source_index_out    (source_index_out),
        .offset_out          (offset_out),
        .beat_class          (beat_class),
        .position_number     (position_number),
        .phrase_zone         (phrase_zone)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("metric_position_tracker_test: FAIL");
            $finish;
        end
    end

    function automatic int pause_length();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int pick_gap();
        if (!idle_mode || $urandom_range(0, 99) < 55)
            return 0;
        return pause_length();
    endfunction

    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if (idle_mode && $urandom_range(0, 99) < 30)
                hold_left = pause_length();
        end
    end

    // Works out where a segment falls in the phrase and advances the phrase position.
    function automatic placement_t place_segment(segment_t s);
        placement_t      p;
        longint unsigned capacity;
        longint unsigned after_pickup;
        longint unsigned in_bar;
        longint unsigned bar;
        int unsigned     following;
        logic            accent_strong;
        logic            accent_medium;
        if (meter_pickup != 0 && phrase_time < meter_pickup)
        begin
            bar = 0;
            in_bar = phrase_time;
        end
        else
        begin
            after_pickup = phrase_time - meter_pickup;
            if (meter_unit == 0 || meter_unit > 16)
                capacity = 0;
            else
                capacity = meter_beats * (16 / meter_unit);
            if (capacity == 0)
            begin
                bar = 1;
                in_bar = 0;
            end
            else
            begin
                bar = after_pickup / capacity + 1;
                in_bar = after_pickup % capacity;
            end
        end
        accent_strong = (in_bar == 0)
              || (meter_unit == 4 && meter_beats == 4 && in_bar == 8)
              || (meter_unit == 8 && meter_beats == 12 && in_bar == 12);
        accent_medium = (meter_unit == 4 && meter_beats == 3 && in_bar == 4)
              || (meter_unit == 8 && meter_beats == 6 && in_bar == 6)
              || (meter_unit == 8 && meter_beats == 9 && (in_bar == 6 || in_bar == 12))
              || (meter_unit == 8 && meter_beats == 12 && (in_bar == 6 || in_bar == 18));
        if (accent_strong)
            p.beat = mpt_pkg::BEAT_STRONG;
        else if (accent_medium)
            p.beat = mpt_pkg::BEAT_MEDIUM;
        else
            p.beat = mpt_pkg::BEAT_WEAK;
        p.measure = bar[mpt_pkg::MEAS_W-1:0];
        p.start = in_bar[mpt_pkg::SIM_W-1:0];
        p.duration = s.duration;
        p.note = s.note;
        p.source = s.source;
        p.offset = s.offset;
        p.position = phrase_ordinal[mpt_pkg::POS_W-1:0];
        if (phrase_ordinal * 3 < meter_segments)
            p.zone = mpt_pkg::ZONE_BEGIN;
        else if (phrase_ordinal * 3 >= 2 * meter_segments)
            p.zone = mpt_pkg::ZONE_END;
        else
            p.zone = mpt_pkg::ZONE_MIDDLE;
        following = phrase_ordinal + 1;
        if (following >= meter_segments || following >= mpt_pkg::MAX_SEGMENTS_DEF)
        begin
            phrase_ordinal = 0;
            phrase_time = 0;
        end
        else
        begin
            phrase_ordinal = following;
            if (phrase_time + s.duration > TIME_MAX)
                phrase_time = TIME_MAX;
            else
                phrase_time = phrase_time + s.duration;
        end
        return p;
    endfunction

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("Mismatch in %s of result %0d: expected %0d, got %0d",
                         field, placements_checked, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        placement_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_placements.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result transaction with no segment outstanding: measure %0d",
                             measure_number);
            end
            else
            begin
                want = pending_placements.pop_front();
                compare_field("measure_number", want.measure, measure_number);
                compare_field("start_in_measure", want.start, start_in_measure);
                compare_field("duration_out", want.duration, duration_out);
                compare_field("note_out", want.note, note_out);
                compare_field("source_index_out", want.source, source_index_out);
                compare_field("offset_out", want.offset, offset_out);
                compare_field("beat_class", want.beat, beat_class);
                compare_field("position_number", want.position, position_number);
                compare_field("phrase_zone", want.zone, phrase_zone);
                class_seen[want.beat]++;
                if (want.measure == 0)
                    pickup_placements++;
                placements_checked++;
            end
        end
    end

    task automatic send_segment(segment_t s);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        duration_sixteenths <= s.duration;
        fixed_note <= s.note;
        source_note_index <= s.source;
        offset_in_note <= s.offset;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_placements.insert(pending_placements.size(), place_segment(s));
    endtask

    task automatic send_duration(logic [9:0] duration);
        segment_t s;
        s.duration = duration;
        s.note = $urandom_range(0, 127);
        s.source = $urandom_range(0, 4095);
        s.offset = $urandom_range(0, 1023);
        send_segment(s);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
    endtask

    task automatic configure_meter(logic [12:0] beats, logic [12:0] unit,
                                   logic [12:0] pickup, logic [12:0] segments);
        drain_results();
        cfg_we <= 1'b1;
        cfg_index <= mpt_pkg::CFG_BEATS;
        cfg_data <= beats;
        @(posedge clk);
        cfg_index <= mpt_pkg::CFG_UNIT;
        cfg_data <= unit;
        @(posedge clk);
        cfg_index <= mpt_pkg::CFG_PICKUP;
        cfg_data <= pickup;
        @(posedge clk);
        cfg_index <= mpt_pkg::CFG_SEGMENTS;
        cfg_data <= segments;
        @(posedge clk);
        cfg_we <= 1'b0;
        meter_beats = beats[5:0];
        meter_unit = unit[4:0];
        meter_pickup = pickup[7:0];
        meter_segments = segments;
        settings_used++;
    endtask

    function automatic segment_t random_segment();
        segment_t s;
        int       pick;
        pick = $urandom_range(0, 9);
        case (pick)
            0, 1, 2, 3, 4, 5, 6:
            begin
                case ($urandom_range(0, 9))
                    0: s.duration = 1;
                    1: s.duration = 2;
                    2: s.duration = 3;
                    3: s.duration = 4;
                    4: s.duration = 6;
                    5: s.duration = 8;
                    6: s.duration = 12;
                    7: s.duration = 16;
                    8: s.duration = 24;
                    default: s.duration = 32;
                endcase
            end
            7: s.duration = 0;
            default: s.duration = $urandom_range(0, 1023);
        endcase
        s.note = $urandom_range(0, 127);
        s.source = $urandom_range(0, 4095);
        s.offset = $urandom_range(0, 1023);
        return s;
    endfunction

    task automatic test_reset_defaults();
        idle_mode = 1'b0;
        send_segment('{10'd0, 7'd0, 12'd0, 10'd0});
        send_segment('{10'd1023, 7'd127, 12'd4095, 10'd1023});
    endtask

    // Each meter runs for exactly one phrase so that the next one starts from zero.
    task automatic test_meter_accents();
        configure_meter(4, 4, 2, 5);
        send_duration(2);
        send_duration(8);
        send_duration(4);
        send_duration(4);
        send_duration(4);
        configure_meter(3, 4, 0, 2);
        repeat (2) send_duration(4);
        configure_meter(6, 8, 0, 2);
        repeat (2) send_duration(6);
        configure_meter(9, 8, 0, 3);
        repeat (3) send_duration(6);
        configure_meter(12, 8, 0, 4);
        repeat (4) send_duration(6);
    endtask

    task automatic test_zero_capacity();
        configure_meter(4, 0, 0, 2);
        repeat (2) send_duration(5);
        configure_meter(0, 4, 0, 1);
        send_duration(7);
        configure_meter(4, 31, 0, 1);
        send_duration(7);
    endtask

    task automatic test_zero_segment_count();
        configure_meter(4, 4, 3, 0);
        repeat (2) send_duration(7);
    endtask

    task automatic test_wide_measure();
        configure_meter(40, 1, 0, 3);
        send_duration(600);
        send_duration(1023);
        send_duration(0);
    endtask

    task automatic test_random_phrases(int target);
        int          sent;
        int          phase;
        int          phase_len;
        logic [12:0] beats;
        logic [12:0] unit;
        logic [12:0] pickup;
        logic [12:0] segments;
        sent = 0;
        phase = 0;
        while (sent < target)
        begin
            case ($urandom_range(0, 9))
                0: begin beats = 4; unit = 4; end
                1: begin beats = 3; unit = 4; end
                2: begin beats = 6; unit = 8; end
                3: begin beats = 9; unit = 8; end
                4: begin beats = 12; unit = 8; end
                5: begin beats = 2; unit = 2; end
                9:
                begin
                    beats = $urandom_range(0, 1) ? 32 : 1;
                    unit = $urandom_range(0, 1) ? 16 : 1;
                end
                default:
                begin
                    beats = $urandom_range(1, 32);
                    unit = $urandom_range(1, 16);
                end
            endcase
            case ($urandom_range(0, 2))
                0: pickup = 0;
                1: pickup = $urandom_range(1, 16);
                default: pickup = $urandom_range(0, 255);
            endcase
            case ($urandom_range(0, 5))
                4: segments = $urandom_range(49, 4096);
                5: segments = $urandom_range(0, 1) ? 1 : 4096;
                default: segments = $urandom_range(1, 48);
            endcase
            configure_meter(beats, unit, pickup, segments);
            idle_mode = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(10, 120);
            for (int k = 0; k < phase_len; k++)
            begin
                send_segment(random_segment());
                sent++;
                // Let the pipeline empty completely now and then mid-phrase.
                if (phase % 2 == 1 && k == phase_len / 2)
                    drain_results();
            end
            phase++;
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_defaults();
        test_meter_accents();
        test_zero_capacity();
        test_zero_segment_count();
        test_wide_measure();
        test_random_phrases(1060);
        drain_results();
        repeat (4 * LATENCY) @(posedge clk);
        $display("Checked %0d segment placements over %0d meter settings,",
                 placements_checked, settings_used);
        $display("beats strong/medium/weak %0d/%0d/%0d, %0d in a pickup, with phrase wraps.",
                 class_seen[0], class_seen[1], class_seen[2], pickup_placements);
        if (mismatch_count == 0)
            $display("metric_position_tracker_test: PASS");
        else
            $display("metric_position_tracker_test: FAIL");
        $finish;
    end

endmodule

### sim.f
sv/mpt_pkg.sv
sv/mpt_divider.sv
sv/metric_position_tracker.sv
verif/metric_position_tracker_test.sv
